// ===== src/fixed_point_alu_unit_macros.svh =====
// Assertion macros for the fixed-point ALU.
// Used by the top level only; needs clk and rst in scope.
`ifndef FIXED_POINT_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_ALU_UNIT_MACROS_SVH

// Checks that cond implies prop in the same cycle.
`define FPA_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Checks that cond implies prop in the next cycle.
`define FPA_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== src/fpa_pkg.sv =====
// Shared types, constants and helper functions of the fixed-point ALU.
// Used by every module of the block; depends on nothing.
package fpa_pkg;

  localparam int FracBitsDef = 8;
  localparam int WordBitsDef = 32;
  localparam int FieldBits   = 32;

  // Operation codes.
  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_MIN = 3'd4,
    FUNC_MAX = 3'd5
  } func_t;

  // Sideband that travels with each item down the pipeline.
  typedef struct packed {
    func_t       func;
    logic [31:0] res;
    logic        ovf;
    logic        dz;
    logic        less;
    logic        equal;
    logic        greater;
    logic        qneg;
  } fpa_side_t;

  // Sign-extends the low w bits of a field to 64 bits.
  function automatic logic [63:0] sext_field(input logic [31:0] x, input int w);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) begin
      y[i] = x[(i < w) ? i : w - 1];
    end
    return y;
  endfunction

  // Low 32 bits of x after wrapping it to a signed w-bit word.
  function automatic logic [31:0] fit_word(input logic [63:0] x, input int w);
    logic [31:0] y;
    for (int i = 0; i < 32; i++) begin
      y[i] = (i < w) ? x[i] : x[w - 1];
    end
    return y;
  endfunction

  // True when x does not fit a signed w-bit word.
  function automatic logic out_of_word(input logic [63:0] x, input int w);
    logic bad;
    bad = 1'b0;
    for (int i = 0; i < 64; i++) begin
      if (i >= w - 1 && x[i] != x[63]) begin
        bad = 1'b1;
      end
    end
    return bad;
  endfunction

endpackage

// ===== src/fpa_front.sv =====
// First pipeline stage: operand decode, compares, add, subtract, min, max,
// the raw multiply and divider setup. Depends on fpa_pkg.
module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDef,
  parameter int WORD_BITS = fpa_pkg::WordBitsDef,
  parameter int OPER_BITS = 32,
  parameter int NUM_BITS  = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  valid,
  input  logic [2:0]            func,
  input  logic [31:0]           a,
  input  logic [31:0]           b,
  output logic                  vld,
  output fpa_pkg::fpa_side_t    side,
  output logic [63:0]           prod,
  output logic [NUM_BITS-1:0]   num,
  output logic [OPER_BITS-1:0]  den
);
  import fpa_pkg::*;

  logic [63:0]          as64, bs64, sum, diff, abs_a, abs_b;
  logic signed [63:0]   prod_c;
  logic [NUM_BITS-1:0]  num_c;
  fpa_side_t            side_c;
  logic                 lt, eq;

  // Decode the item and compute everything this stage produces.
  always_comb begin
    as64   = sext_field(a, OPER_BITS);
    bs64   = sext_field(b, OPER_BITS);
    lt     = $signed(as64) < $signed(bs64);
    eq     = as64 == bs64;
    sum    = as64 + bs64;
    diff   = as64 - bs64;
    abs_a  = as64[63] ? -as64 : as64;
    abs_b  = bs64[63] ? -bs64 : bs64;
    prod_c = $signed(as64[31:0]) * $signed(bs64[31:0]);
    num_c  = NUM_BITS'(abs_a[OPER_BITS-1:0]);
    num_c  = num_c << FRAC_BITS;

    side_c.func    = func_t'(func);
    side_c.res     = '0;
    side_c.ovf     = 1'b0;
    side_c.dz      = 1'b0;
    side_c.less    = lt;
    side_c.equal   = eq;
    side_c.greater = !lt && !eq;
    side_c.qneg    = as64[63] ^ bs64[63];
    case (func_t'(func))
      FUNC_ADD: side_c.res = fit_word(sum, WORD_BITS);
      FUNC_SUB: side_c.res = fit_word(diff, WORD_BITS);
      FUNC_DIV: side_c.dz  = (bs64 == 64'd0);
      FUNC_MIN: side_c.res = (lt || eq) ? as64[31:0] : bs64[31:0];
      FUNC_MAX: side_c.res = (!lt) ? as64[31:0] : bs64[31:0];
      default:  side_c.res = '0;
    endcase
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= valid;
    end
    if (en) begin
      side <= side_c;
      prod <= prod_c;
      num  <= num_c;
      den  <= abs_b[OPER_BITS-1:0];
    end
  end

endmodule

// ===== src/fpa_mul_stage.sv =====
// Second pipeline stage: scales the product, truncating toward zero, and
// flags multiply overflow. Depends on fpa_pkg.
module fpa_mul_stage #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDef,
  parameter int WORD_BITS = fpa_pkg::WordBitsDef,
  parameter int OPER_BITS = 32,
  parameter int NUM_BITS  = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vld_in,
  input  fpa_pkg::fpa_side_t    side_in,
  input  logic [63:0]           prod,
  input  logic [NUM_BITS-1:0]   num_in,
  input  logic [OPER_BITS-1:0]  den_in,
  output logic                  vld,
  output fpa_pkg::fpa_side_t    side,
  output logic [NUM_BITS-1:0]   num,
  output logic [OPER_BITS-1:0]  den
);
  import fpa_pkg::*;

  localparam logic [63:0] RoundAdd = (64'd1 << FRAC_BITS) - 64'd1;

  logic [63:0] adj, q;
  fpa_side_t   side_c;

  // A negative product gets a bias so the shift rounds toward zero.
  always_comb begin
    adj    = prod[63] ? prod + RoundAdd : prod;
    q      = 64'($signed(adj) >>> FRAC_BITS);
    side_c = side_in;
    if (side_in.func == FUNC_MUL) begin
      side_c.res = fit_word(q, WORD_BITS);
      side_c.ovf = out_of_word(q, WORD_BITS);
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
    if (en) begin
      side <= side_c;
      num  <= num_in;
      den  <= den_in;
    end
  end

endmodule

// ===== src/fpa_div_stage.sv =====
// One stage of the restoring divider: produces one quotient bit of the
// magnitude division. Depends on fpa_pkg.
module fpa_div_stage #(
  parameter int OPER_BITS = 32,
  parameter int NUM_BITS  = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vld_in,
  input  fpa_pkg::fpa_side_t    side_in,
  input  logic [OPER_BITS-1:0]  rem_in,
  input  logic [NUM_BITS-1:0]   num_in,
  input  logic [NUM_BITS-1:0]   quo_in,
  input  logic [OPER_BITS-1:0]  den_in,
  output logic                  vld,
  output fpa_pkg::fpa_side_t    side,
  output logic [OPER_BITS-1:0]  rem,
  output logic [NUM_BITS-1:0]   num,
  output logic [NUM_BITS-1:0]   quo,
  output logic [OPER_BITS-1:0]  den
);
  import fpa_pkg::*;

  logic [OPER_BITS:0]   trial, diff;
  logic                 ge;

  // Bring down the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial = {rem_in, num_in[NUM_BITS-1]};
    ge    = trial >= {1'b0, den_in};
    diff  = trial - {1'b0, den_in};
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
    if (en) begin
      side <= side_in;
      rem  <= ge ? diff[OPER_BITS-1:0] : trial[OPER_BITS-1:0];
      num  <= num_in << 1;
      quo  <= {quo_in[NUM_BITS-2:0], ge};
      den  <= den_in;
    end
  end

endmodule

// ===== src/fpa_back.sv =====
// Last pipeline stage: signs the quotient, flags divide overflow, picks the
// result and holds the output register. Depends on fpa_pkg.
module fpa_back #(
  parameter int WORD_BITS = fpa_pkg::WordBitsDef,
  parameter int NUM_BITS  = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vld_in,
  input  fpa_pkg::fpa_side_t    side_in,
  input  logic [NUM_BITS-1:0]   quo,
  output logic                  vld,
  output logic [31:0]           result,
  output logic                  less,
  output logic                  equal,
  output logic                  greater,
  output logic                  div_zero,
  output logic                  overflow
);
  import fpa_pkg::*;

  logic [63:0] q64;
  logic [31:0] res_c;
  logic        ovf_c;

  // Apply the quotient sign and choose the final result.
  always_comb begin
    q64   = 64'(quo);
    if (side_in.qneg) begin
      q64 = -q64;
    end
    res_c = side_in.res;
    ovf_c = side_in.ovf;
    if (side_in.func == FUNC_DIV) begin
      if (side_in.dz) begin
        res_c = '0;
        ovf_c = 1'b0;
      end else begin
        res_c = fit_word(q64, WORD_BITS);
        ovf_c = out_of_word(q64, WORD_BITS);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
    if (en) begin
      result   <= res_c;
      less     <= side_in.less;
      equal    <= side_in.equal;
      greater  <= side_in.greater;
      div_zero <= side_in.dz;
      overflow <= ovf_c;
    end
  end

endmodule

// ===== src/fixed_point_alu_unit.sv =====
// Signed fixed-point ALU: add, subtract, multiply, divide, min and max.
// Items pass the front stage, the multiply stage, the one-bit-per-stage divider
// and the output register; throughput is one item per cycle unless stalled.
// The whole pipeline advances together and stalls only while a result waits.
// Synchronous reset clears the valid bits; payload registers are not reset.
module fixed_point_alu_unit #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDef,
  parameter int WORD_BITS = fpa_pkg::WordBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [2:0]  func,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [31:0] result,
  output logic        less,
  output logic        equal,
  output logic        greater,
  output logic        div_zero,
  output logic        overflow
);
  import fpa_pkg::*;
  `include "fixed_point_alu_unit_macros.svh"

  localparam int OperBits = (WORD_BITS < FieldBits) ? WORD_BITS : FieldBits;
  localparam int NumBits  = OperBits + FRAC_BITS;

  logic en;

  logic                 f_vld;
  fpa_side_t            f_side;
  logic [63:0]          f_prod;
  logic [NumBits-1:0]   f_num;
  logic [OperBits-1:0]  f_den;

  logic                 d_vld  [NumBits+1];
  fpa_side_t            d_side [NumBits+1];
  logic [OperBits-1:0]  d_rem  [NumBits+1];
  logic [NumBits-1:0]   d_num  [NumBits+1];
  logic [NumBits-1:0]   d_quo  [NumBits+1];
  logic [OperBits-1:0]  d_den  [NumBits+1];

  // Every stage moves when the output register is free or being taken.
  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  fpa_front #(
    .FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS),
    .OPER_BITS(OperBits), .NUM_BITS(NumBits)
  ) u_front (
    .clk(clk), .rst(rst), .en(en), .valid(req_valid),
    .func(func), .a(a), .b(b),
    .vld(f_vld), .side(f_side), .prod(f_prod), .num(f_num), .den(f_den)
  );

  fpa_mul_stage #(
    .FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS),
    .OPER_BITS(OperBits), .NUM_BITS(NumBits)
  ) u_mul (
    .clk(clk), .rst(rst), .en(en), .vld_in(f_vld), .side_in(f_side),
    .prod(f_prod), .num_in(f_num), .den_in(f_den),
    .vld(d_vld[0]), .side(d_side[0]), .num(d_num[0]), .den(d_den[0])
  );

  // The divider starts with an empty remainder and quotient.
  assign d_rem[0] = '0;
  assign d_quo[0] = '0;

  for (genvar i = 0; i < NumBits; i++) begin : g_div
    fpa_div_stage #(
      .OPER_BITS(OperBits), .NUM_BITS(NumBits)
    ) u_stage (
      .clk(clk), .rst(rst), .en(en),
      .vld_in(d_vld[i]), .side_in(d_side[i]), .rem_in(d_rem[i]),
      .num_in(d_num[i]), .quo_in(d_quo[i]), .den_in(d_den[i]),
      .vld(d_vld[i+1]), .side(d_side[i+1]), .rem(d_rem[i+1]),
      .num(d_num[i+1]), .quo(d_quo[i+1]), .den(d_den[i+1])
    );
  end

  fpa_back #(
    .WORD_BITS(WORD_BITS), .NUM_BITS(NumBits)
  ) u_back (
    .clk(clk), .rst(rst), .en(en),
    .vld_in(d_vld[NumBits]), .side_in(d_side[NumBits]), .quo(d_quo[NumBits]),
    .vld(rsp_valid), .result(result), .less(less), .equal(equal),
    .greater(greater), .div_zero(div_zero), .overflow(overflow)
  );

  // Exactly one compare flag holds for every result item.
  `FPA_ASSERT_IMPL(a_cmp_onehot, rsp_valid, $onehot({less, equal, greater}), "compare flags not one-hot")
  // A divide by zero gives zero and no overflow.
  `FPA_ASSERT_IMPL(a_dz_result, rsp_valid && div_zero, result == 32'd0 && !overflow, "bad divide-by-zero result")
  // A waiting result blocks new items until it is taken.
  `FPA_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid, "result lost while stalled")

endmodule
